/* hw/rtl/sfe_pkg.sv */
// ============================================================================
// sfe_pkg
// Shared types and constants for the smoothstep fade envelope core.
// ============================================================================
`default_nettype none

package sfe_pkg;

    // Default width of the elapsed-time counter.
    localparam int TIME_BITS_DEF = 24;

    // Field widths.
    localparam int LEN_W     = 16;
    localparam int ELAPSED_W = 12;
    localparam int ALPHA_W   = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Fixed-point constants: p is Q0.16 on a 17-bit carrier, alpha is Q1.15.
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [17:0] THREE_Q16    = 18'd196608;
    localparam logic [15:0] FULL_Q15     = 16'h8000;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Item kinds.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FADEIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADEOUT = 2'd2;

    // Reported phase codes.
    localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FADE_IN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD     = 2'd2;
    localparam logic [PHASE_W-1:0] PH_FADE_OUT = 2'd3;

    // Time classification against the latched lengths.
    localparam logic [1:0] CLS_FADE_IN  = 2'd0;
    localparam logic [1:0] CLS_HOLD     = 2'd1;
    localparam logic [1:0] CLS_FADE_OUT = 2'd2;
    localparam logic [1:0] CLS_END      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic classify;
        logic div_step;
        logic form_p;
        logic square;
        logic mult;
        logic emit;
    } t_sfe_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       armed;
        logic [1:0] cls;
    } t_sfe_stat;

endpackage

`default_nettype wire

/* hw/rtl/sfe_ctrl.sv */
// ============================================================================
// sfe_ctrl
// Sequencer for the envelope core: accepts an item, steps the datapath
// through classification, division and the smoothstep products, and owns
// the output valid flag.
// ============================================================================
`default_nettype none

module sfe_ctrl
    import sfe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s_tvalid,
    input  wire logic      i_op,
    input  wire logic      i_m_tready,
    input  wire t_sfe_stat i_stat,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    output t_sfe_cmd       o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PFORM = 3'd3;
    localparam logic [2:0] ST_SQR   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Next-state and command decode.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_op == OP_START || !i_stat.armed) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_CLASS;
                    end
                end
            end
            ST_CLASS: begin
                o_cmd.classify = 1'b1;
                n_cnt          = '0;
                if (i_stat.cls == CLS_FADE_IN || i_stat.cls == CLS_FADE_OUT) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_PFORM;
                end
            end
            ST_PFORM: begin
                o_cmd.form_p = 1'b1;
                n_state      = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // Load the output register once it is free or being drained.
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sfe_dpath.sv */
// ============================================================================
// sfe_dpath
// Datapath of the envelope core: length registers, time counter, phase
// classification, restoring divider and the two smoothstep multiplies.
// ============================================================================
`default_nettype none

module sfe_dpath
    import sfe_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_sfe_cmd             i_cmd,
    input  wire logic                 i_op,
    input  wire logic [ELAPSED_W-1:0] i_elapsed,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data,
    output t_sfe_stat                 o_stat,
    output logic [ALPHA_W-1:0]        o_alpha,
    output logic [PHASE_W-1:0]        o_phase,
    output logic                      o_active
);

    // Configuration and latched lengths.
    logic [LEN_W-1:0] r_cfg_in, r_cfg_hold, r_cfg_out;
    logic [LEN_W-1:0] r_lat_in, r_lat_hold, r_lat_out;

    // Envelope state.
    logic [TIME_BITS-1:0] r_time;
    logic                 r_armed;

    // Divider, smoothstep and result registers.
    logic [LEN_W-1:0]   r_rem, r_div, r_quo;
    logic               r_fade_out;
    logic [16:0]        r_p;
    logic [33:0]        r_p2;
    logic [17:0]        r_s;
    logic [ALPHA_W-1:0] r_alpha;
    logic [PHASE_W-1:0] r_phase;
    logic               r_active;
    logic [ALPHA_W-1:0] r_out_alpha;
    logic [PHASE_W-1:0] r_out_phase;
    logic               r_out_active;

    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_time_sat;
    logic [16:0]          w_out_start;
    logic [17:0]          w_end;
    logic [1:0]           w_cls;
    logic [LEN_W-1:0]     w_e;
    logic [17:0]          w_trial;
    logic [51:0]          w_prod;

    // Saturating time update.
    assign w_sum      = {1'b0, r_time} + (TIME_BITS + 1)'(i_elapsed);
    assign w_time_sat = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];

    // Phase boundaries and classification of the current time.
    assign w_out_start = {1'b0, r_lat_in} + {1'b0, r_lat_hold};
    assign w_end       = {1'b0, w_out_start} + {2'b00, r_lat_out};

    always_comb begin
        if (r_time < TIME_BITS'(r_lat_in)) begin
            w_cls = CLS_FADE_IN;
        end else if (r_time < TIME_BITS'(w_out_start)) begin
            w_cls = CLS_HOLD;
        end else if (r_time < TIME_BITS'(w_end)) begin
            w_cls = CLS_FADE_OUT;
        end else begin
            w_cls = CLS_END;
        end
    end

    // Offset into the fade-out; it is below the fade-out length, so 16 bits hold it.
    assign w_e = r_time[LEN_W-1:0] - w_out_start[LEN_W-1:0];

    // One restoring division step: shift in a zero and try to subtract.
    assign w_trial = {1'b0, r_rem, 1'b0} - {2'b00, r_div};

    // Second smoothstep product: p^2 * (3 - 2p), truncated to Q1.15.
    assign w_prod = {18'd0, r_p2} * {34'd0, r_s};

    assign o_stat.armed = r_armed;
    assign o_stat.cls   = w_cls;
    assign o_alpha      = r_out_alpha;
    assign o_phase      = r_out_phase;
    assign o_active     = r_out_active;

    // Control state: configuration, latched lengths, counter and armed flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in   <= '0;
            r_cfg_hold <= '0;
            r_cfg_out  <= '0;
            r_lat_in   <= '0;
            r_lat_hold <= '0;
            r_lat_out  <= '0;
            r_time     <= '0;
            r_armed    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FADEIN:  r_cfg_in   <= i_cfg_data;
                    REG_HOLD:    r_cfg_hold <= i_cfg_data;
                    REG_FADEOUT: r_cfg_out  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                if (i_op == OP_START) begin
                    r_time     <= '0;
                    r_armed    <= 1'b1;
                    r_lat_in   <= r_cfg_in;
                    r_lat_hold <= r_cfg_hold;
                    r_lat_out  <= r_cfg_out;
                end else if (r_armed) begin
                    r_time <= w_time_sat;
                end
            end
            if (i_cmd.classify && w_cls == CLS_END) begin
                r_armed <= 1'b0;
            end
        end
    end

    // Arithmetic and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_alpha  <= '0;
            r_phase  <= PH_IDLE;
            r_active <= (i_op == OP_START);
        end
        if (i_cmd.classify) begin
            r_quo <= '0;
            case (w_cls)
                CLS_FADE_IN: begin
                    r_rem      <= r_time[LEN_W-1:0];
                    r_div      <= r_lat_in;
                    r_fade_out <= 1'b0;
                    r_phase    <= PH_FADE_IN;
                    r_active   <= 1'b1;
                end
                CLS_HOLD: begin
                    r_alpha  <= FULL_Q15;
                    r_phase  <= PH_HOLD;
                    r_active <= 1'b1;
                end
                CLS_FADE_OUT: begin
                    r_rem      <= w_e;
                    r_div      <= r_lat_out;
                    r_fade_out <= 1'b1;
                    r_phase    <= PH_FADE_OUT;
                    r_active   <= 1'b1;
                end
                default: begin
                    r_alpha  <= '0;
                    r_phase  <= PH_IDLE;
                    r_active <= 1'b0;
                end
            endcase
        end
        if (i_cmd.div_step) begin
            if (!w_trial[17]) begin
                r_rem <= w_trial[LEN_W-1:0];
                r_quo <= {r_quo[LEN_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[LEN_W-2:0], 1'b0};
                r_quo <= {r_quo[LEN_W-2:0], 1'b0};
            end
        end
        // The fade-out runs from 1.0 down, so p is the complement of the fraction.
        if (i_cmd.form_p) begin
            r_p <= r_fade_out ? (ONE_Q16 - {1'b0, r_quo}) : {1'b0, r_quo};
        end
        if (i_cmd.square) begin
            r_p2 <= {17'd0, r_p} * {17'd0, r_p};
            r_s  <= THREE_Q16 - {r_p, 1'b0};
        end
        if (i_cmd.mult) begin
            r_alpha <= w_prod[48:33];
        end
        if (i_cmd.emit) begin
            r_out_alpha  <= r_alpha;
            r_out_phase  <= r_phase;
            r_out_active <= r_active;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/smoothstep_fade_envelope_core.sv */
// ============================================================================
// smoothstep_fade_envelope_core
// Brightness envelope with smoothstep fade-in, full hold and smoothstep
// fade-out, driven by start and tick items.
// ============================================================================
//
// Usage:
//   Write the three lengths on the configuration channel while idle; a start
//   item (tuser = 1) latches them, clears the time counter and arms the
//   envelope. Tick items (tuser = 0) carry elapsed ticks in tdata and each
//   returns one item with alpha (Q1.15) in tdata and phase/active in tuser.
//   A start item or a tick while disarmed goes straight to the output register;
//   a tick in hold or at envelope end is classified first, and a tick inside
//   a fade then also passes the 16-step restoring divider, the forming of p
//   and the two multiply stages. Items are handled one at a time; the next
//   item is taken the cycle after the result is loaded.
//   A finished result sits in the output register until taken; when the
//   receiver stalls the core holds the result and the next one waits in the
//   final sequencer state, with the input channel not ready.
//   Reset (synchronous, active low) clears the lengths, the time counter and
//   the armed flag; the configuration channel is always ready.
//
`default_nettype none

module smoothstep_fade_envelope_core
    import sfe_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input items.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // [11:0] elapsed, [15:12] zero
    input  wire logic                 s_axis_tuser,  // [0] op
    // Result items.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // [15:0] alpha
    output logic [2:0]                m_axis_tuser,  // [1:0] phase, [2] active
    // Configuration writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LEN_W-1:0]     i_cfg_data
);

    t_sfe_cmd           w_cmd;
    t_sfe_stat          w_stat;
    logic [PHASE_W-1:0] w_phase;
    logic               w_active;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    sfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state.
    sfe_dpath #(
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (s_axis_tuser),
        .i_elapsed   (s_axis_tdata[ELAPSED_W-1:0]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_alpha     (m_axis_tdata),
        .o_phase     (w_phase),
        .o_active    (w_active)
    );

    assign m_axis_tuser = {w_active, w_phase};

endmodule

`default_nettype wire

/* hw/rtl/sfe_checker.sv */
// ============================================================================
// sfe_checker
// Port-level checks on the result channel of the envelope core.
// ============================================================================
`default_nettype none

module sfe_checker
    import sfe_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // A stalled result keeps its payload.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Alpha never exceeds full scale.
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= FULL_Q15)
        else $error("alpha above full scale");

    // Any reported fade or hold phase implies an active envelope.
    a_phase_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] != PH_IDLE |-> m_axis_tuser[2])
        else $error("phase reported while inactive");

    // The hold phase always shows full level.
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == PH_HOLD |-> m_axis_tdata == FULL_Q15)
        else $error("hold phase not at full level");

    // An inactive envelope shows zero.
    a_idle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata == 16'h0000)
        else $error("inactive result with nonzero alpha");

endmodule

bind smoothstep_fade_envelope_core sfe_checker u_sfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* sim/tb_smoothstep_fade_envelope_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_smoothstep_fade_envelope_core
// Self-checking bench for the smoothstep fade envelope core. A short table of
// directed items covers the extremes, the skipped zero-length phases and
// register writes during a run. Random envelope runs follow, under changing
// sender and receiver idling. Every result item is checked, against the table's
// level where it gives one and else against an in-bench envelope predictor.
// ============================================================================

module tb_smoothstep_fade_envelope_core;
    import sfe_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 175;
    localparam int MAX_GAP       = 16;
    localparam int MAX_RUN_TICKS = 80;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS_DEF) - 1;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [PHASE_W-1:0] phase;
        logic               active;
    } t_level;

    typedef struct packed {
        t_level      lvl;
        logic [31:0] seq;
    } t_pending;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [LEN_W-1:0]     data;
        logic                 op;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 known;
        t_level               lvl;
    } t_stim_row;

    localparam t_level NO_LEVEL = '0;

    // Clock, reset and DUT ports.
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [11:0] elapsed, [15:12] zero
    logic                 s_axis_tuser;   // [0] op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // [15:0] alpha
    logic [2:0]           m_axis_tuser;   // [1:0] phase, [2] active
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEN_W-1:0]     i_cfg_data;

    // Envelope predictor state: live registers and lengths latched at start.
    logic [LEN_W-1:0] cfg_fadein;
    logic [LEN_W-1:0] cfg_hold;
    logic [LEN_W-1:0] cfg_fadeout;
    longint unsigned  lat_fadein;
    longint unsigned  lat_hold;
    longint unsigned  lat_fadeout;
    longint unsigned  env_time;
    logic             env_armed;

    t_pending  expected_levels[$];
    t_stim_row stim_rows[$];
    int        items_sent    = 0;
    int        err_count     = 0;
    int        cycles        = 0;
    int        snd_idle_pct  = 0;
    int        rcv_stall_pct = 0;

    smoothstep_fade_envelope_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Smoothstep 3p^2 - 2p^3 with p in Q0.16 (up to 1.0), truncated to Q1.15.
    function automatic logic [ALPHA_W-1:0] smoothstep_q15(longint unsigned p);
        longint unsigned sq;
        longint unsigned slope;
        sq    = p * p;
        slope = 3 * 65536 - 2 * p;
        return ALPHA_W'((sq * slope) >> 33);
    endfunction

    function automatic t_level make_level(logic [ALPHA_W-1:0] alpha,
                                          logic [PHASE_W-1:0] phase, logic active);
        t_level lv;
        lv.alpha  = alpha;
        lv.phase  = phase;
        lv.active = active;
        return lv;
    endfunction

    // Advances the predicted envelope by one accepted item.
    function automatic t_level predict_envelope(logic op, logic [ELAPSED_W-1:0] el);
        longint unsigned hold_at;
        longint unsigned out_at;
        longint unsigned end_at;
        longint unsigned p;
        t_level          lv;
        lv = make_level('0, PH_IDLE, 1'b0);
        if (op == OP_START) begin
            env_time    = 0;
            env_armed   = 1'b1;
            lat_fadein  = cfg_fadein;
            lat_hold    = cfg_hold;
            lat_fadeout = cfg_fadeout;
            lv.active   = 1'b1;
        end else if (env_armed) begin
            hold_at  = lat_fadein;
            out_at   = hold_at + lat_hold;
            end_at   = out_at + lat_fadeout;
            env_time = env_time + el;
            if (env_time > TIME_MAX) begin
                env_time = TIME_MAX;
            end
            if (env_time < hold_at) begin
                p  = (env_time << 16) / lat_fadein;
                lv = make_level(smoothstep_q15(p), PH_FADE_IN, 1'b1);
            end else if (env_time < out_at) begin
                lv = make_level(FULL_Q15, PH_HOLD, 1'b1);
            end else if (env_time < end_at) begin
                p  = 65536 - (((env_time - out_at) << 16) / lat_fadeout);
                lv = make_level(smoothstep_q15(p), PH_FADE_OUT, 1'b1);
            end else begin
                env_armed = 1'b0;
            end
        end
        return lv;
    endfunction

    task automatic report_mismatch(int seq, string field, int got, int want);
        $display("MISMATCH item %0d %s: got %0d, expected %0d", seq, field, got, want);
        err_count++;
    endtask

    // Receiver: ready drops at random according to the current stall rate.
    always @(posedge i_clk) begin
        m_axis_tready <= (rcv_stall_pct == 0) || ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pending head;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch(-1, "unexpected result alpha", int'(m_axis_tdata), 0);
            end else begin
                head = expected_levels.pop_front();
                if (m_axis_tdata !== head.lvl.alpha)
                    report_mismatch(int'(head.seq), "alpha", int'(m_axis_tdata),
                                    int'(head.lvl.alpha));
                if (m_axis_tuser[1:0] !== head.lvl.phase)
                    report_mismatch(int'(head.seq), "phase", int'(m_axis_tuser[1:0]),
                                    int'(head.lvl.phase));
                if (m_axis_tuser[2] !== head.lvl.active)
                    report_mismatch(int'(head.seq), "active", int'(m_axis_tuser[2]),
                                    int'(head.lvl.active));
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one item after a random gap and records the level it should produce.
    task automatic send_item(logic op, logic [ELAPSED_W-1:0] el, logic known, t_level want);
        int       gap;
        t_level   pred;
        t_pending ent;
        gap = 0;
        while (snd_idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < snd_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, el};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pred    = predict_envelope(op, el);
        ent.lvl = known ? want : pred;
        ent.seq = items_sent;
        expected_levels.push_back(ent);
        items_sent++;
    endtask

    // Stops sending until every expected result item has come back.
    task automatic hold_until_drained(int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FADEIN:  cfg_fadein  = data;
            REG_HOLD:    cfg_hold    = data;
            REG_FADEOUT: cfg_fadeout = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lengths lean toward zero, one full extreme and short fades.
    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            3, 4:    return LEN_W'($urandom_range(1, 8));
            5, 6:    return LEN_W'($urandom_range(1, 300));
            7, 8:    return LEN_W'($urandom_range(1, 5000));
            default: return LEN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Elapsed ticks scaled so a run crosses its phases in a handful of items.
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        longint unsigned span;
        longint unsigned step_max;
        span = lat_fadein + lat_hold + lat_fadeout;
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return ELAPSED_W'($urandom_range(0, 4095));
            default: begin
                step_max = span / $urandom_range(3, 20) + 1;
                if (step_max > 4095) begin
                    step_max = 4095;
                end
                return ELAPSED_W'($urandom_range(0, int'(step_max)));
            end
        endcase
    endfunction

    // One envelope: a start, ticks until it ends or the tick limit is hit, sometimes a restart or stray ticks.
    task automatic random_run();
        int ticks;
        send_item(OP_START, ELAPSED_W'($urandom_range(0, 4095)), 1'b0, NO_LEVEL);
        ticks = 0;
        while (env_armed && ticks < MAX_RUN_TICKS) begin
            if ($urandom_range(0, 99) < 3) begin
                send_item(OP_START, ELAPSED_W'($urandom_range(0, 4095)), 1'b0, NO_LEVEL);
            end else begin
                send_item(OP_TICK, pick_elapsed(), 1'b0, NO_LEVEL);
            end
            ticks++;
        end
        if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 3))
                send_item(OP_TICK, ELAPSED_W'($urandom_range(0, 4095)), 1'b0, NO_LEVEL);
        end
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, int n_items);
        int target;
        target = items_sent + n_items;
        hold_until_drained(SETTLE_CYCLES);
        snd_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 40) begin
                // New lengths are only written while the core is idle.
                hold_until_drained(SETTLE_CYCLES);
                write_reg(REG_FADEIN, rand_len());
                write_reg(REG_HOLD, rand_len());
                write_reg(REG_FADEOUT, rand_len());
                if ($urandom_range(0, 9) == 0) begin
                    write_reg(REG_UNUSED, LEN_W'($urandom_range(0, 65535)));
                end
            end else if ($urandom_range(0, 99) < 5) begin
                hold_until_drained(0);
            end
            random_run();
        end
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        t_stim_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        stim_rows.push_back(r);
    endtask

    task automatic add_item(logic op, logic [ELAPSED_W-1:0] el, logic known, t_level lvl);
        t_stim_row r;
        r         = '0;
        r.op      = op;
        r.elapsed = el;
        r.known   = known;
        r.lvl     = lvl;
        stim_rows.push_back(r);
    endtask

    initial begin
        t_level off_level;
        t_level armed_level;
        t_level full_out;
        off_level   = make_level('0, PH_IDLE, 1'b0);
        armed_level = make_level('0, PH_IDLE, 1'b1);
        full_out    = make_level(FULL_Q15, PH_FADE_OUT, 1'b1);

        cfg_fadein  = '0;
        cfg_hold    = '0;
        cfg_fadeout = '0;
        lat_fadein  = 0;
        lat_hold    = 0;
        lat_fadeout = 0;
        env_time    = 0;
        env_armed   = 1'b0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_TICK;
        m_axis_tready <= 1'b1;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_FADEIN;
        i_cfg_data    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full run through all three phases, with the boundaries hit exactly.
        add_cfg(REG_FADEIN, 16'd100);
        add_cfg(REG_HOLD, 16'd50);
        add_cfg(REG_FADEOUT, 16'd100);
        add_item(OP_TICK, 12'd7, 1'b1, off_level);
        add_item(OP_START, 12'd0, 1'b1, armed_level);
        add_item(OP_TICK, 12'd0, 1'b1, make_level('0, PH_FADE_IN, 1'b1));
        add_item(OP_TICK, 12'd50, 1'b0, NO_LEVEL);
        add_item(OP_TICK, 12'd50, 1'b1, make_level(FULL_Q15, PH_HOLD, 1'b1));
        add_item(OP_TICK, 12'd49, 1'b1, make_level(FULL_Q15, PH_HOLD, 1'b1));
        add_item(OP_TICK, 12'd1, 1'b1, full_out);
        add_item(OP_TICK, 12'd99, 1'b0, NO_LEVEL);
        add_item(OP_TICK, 12'd1, 1'b1, off_level);
        add_item(OP_TICK, 12'd4095, 1'b1, off_level);
        // All lengths zero: the first tick ends the envelope. Index 3 is ignored.
        add_cfg(REG_FADEIN, 16'd0);
        add_cfg(REG_HOLD, 16'd0);
        add_cfg(REG_FADEOUT, 16'd0);
        add_cfg(REG_UNUSED, 16'hFFFF);
        add_item(OP_START, 12'd4095, 1'b1, armed_level);
        add_item(OP_TICK, 12'd0, 1'b1, off_level);
        // Longest fades; a write during the run only counts at the next start.
        add_cfg(REG_FADEIN, 16'hFFFF);
        add_cfg(REG_FADEOUT, 16'hFFFF);
        add_item(OP_START, 12'd0, 1'b1, armed_level);
        add_item(OP_TICK, 12'd4095, 1'b0, NO_LEVEL);
        add_cfg(REG_FADEIN, 16'd1);
        add_item(OP_TICK, 12'hAAA, 1'b0, NO_LEVEL);
        add_item(OP_TICK, 12'h555, 1'b0, NO_LEVEL);
        add_item(OP_START, 12'd0, 1'b1, armed_level);
        add_item(OP_TICK, 12'd0, 1'b1, make_level('0, PH_FADE_IN, 1'b1));
        add_item(OP_TICK, 12'd1, 1'b1, full_out);
        // Zero-length fade-in and hold go straight to the fade-out.
        add_cfg(REG_FADEIN, 16'd0);
        add_cfg(REG_FADEOUT, 16'd3);
        add_item(OP_START, 12'd0, 1'b1, armed_level);
        add_item(OP_TICK, 12'd0, 1'b1, full_out);
        add_item(OP_TICK, 12'd1, 1'b0, NO_LEVEL);
        add_item(OP_TICK, 12'd2, 1'b1, off_level);
        // Hold only.
        add_cfg(REG_HOLD, 16'hFFFF);
        add_cfg(REG_FADEOUT, 16'd0);
        add_item(OP_START, 12'd0, 1'b1, armed_level);
        add_item(OP_TICK, 12'd4095, 1'b1, make_level(FULL_Q15, PH_HOLD, 1'b1));

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                hold_until_drained(SETTLE_CYCLES);
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_item(stim_rows[i].op, stim_rows[i].elapsed,
                          stim_rows[i].known, stim_rows[i].lvl);
            end
        end

        // Random envelopes under each idling pattern.
        random_phase(0, 0, PHASE_ITEMS);
        random_phase(69, 0, PHASE_ITEMS);
        random_phase(0, 69, PHASE_ITEMS);
        random_phase(19, 19, PHASE_ITEMS);

        hold_until_drained(SETTLE_CYCLES);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* smoothstep_fade_envelope_core.f */
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_ctrl.sv
hw/rtl/sfe_dpath.sv
hw/rtl/smoothstep_fade_envelope_core.sv
hw/rtl/sfe_checker.sv
sim/tb_smoothstep_fade_envelope_core.sv
